### sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and constants of the assembly line tokenizer: character codes,
// result tags, store selects and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

   // default configuration
   localparam int LINE_MAX_DEFAULT  = 64;
   localparam int ADDR_BITS_DEFAULT = 16;

   // field widths fixed by the interface
   localparam int CHAR_W     = 8;
   localparam int PART_W     = 3;
   localparam int KIND_W     = 2;
   localparam int LINE_NUM_W = 20;
   localparam int OUT_ADDR_W = 16;

   localparam logic [LINE_NUM_W-1:0] LINE_SAT = '1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [CHAR_W-1:0] CH_SLASH     = 8'd47;
   localparam logic [CHAR_W-1:0] CH_AT        = 8'd64;
   localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'd40;
   localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'd41;
   localparam logic [CHAR_W-1:0] CH_EQUALS    = 8'd61;
   localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'd59;

   // part tags
   localparam logic [PART_W-1:0] PART_SYMBOL = 3'd0;
   localparam logic [PART_W-1:0] PART_DEST   = 3'd1;
   localparam logic [PART_W-1:0] PART_COMP   = 3'd2;
   localparam logic [PART_W-1:0] PART_JUMP   = 3'd3;
   localparam logic [PART_W-1:0] PART_DELIM  = 3'd4;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_ADDRESS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LABEL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   // which character goes into the line buffer
   typedef logic [1:0] store_sel_type;
   localparam store_sel_type STORE_NONE  = 2'd0;
   localparam store_sel_type STORE_INPUT = 2'd1;
   localparam store_sel_type STORE_SLASH = 2'd2;
   localparam store_sel_type STORE_HELD  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic          accept;
      store_sel_type store_sel;
      logic          set_slash;
      logic          clr_slash;
      logic          set_comment;
      logic          classify;
      logic          read_char;
      logic          next_char;
      logic          clear_line;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_comment;
      logic slash_pending;
      logic is_end;
      logic is_newline;
      logic is_slash;
      logic is_blank;
      logic line_empty;
      logic emit_final;
   } status_type;

endpackage

`default_nettype wire

### sv/alt_dpath.sv
// ----------------------------------------------------------------------------
// alt_dpath
// Datapath of the tokenizer: line buffer, comment and slash flags, first '='
// and ';' positions, line and address counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_dpath #(
   parameter int LINE_MAX  = alt_pkg::LINE_MAX_DEFAULT,
   parameter int ADDR_BITS = alt_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_tdata,
   input  wire logic [0:0]         req_tuser,
   input  wire alt_pkg::cmd_type   cmd,
   output alt_pkg::status_type     status,
   output logic [47:0]             rsp_tdata,
   output logic [5:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam int IDX_W = $clog2(LINE_MAX);

   // held input
   logic [alt_pkg::CHAR_W-1:0] char_ff;
   logic                       end_ff;

   // line state
   logic [alt_pkg::CHAR_W-1:0] mem [LINE_MAX];
   logic [LEN_W-1:0]           len_ff;
   logic                       slash_ff;
   logic                       comment_ff;
   logic                       eq_seen_ff;
   logic [IDX_W-1:0]           eq_pos_ff;
   logic                       sc_seen_ff;
   logic [IDX_W-1:0]           sc_pos_ff;
   logic                       ovf_ff;
   logic [alt_pkg::CHAR_W-1:0] first_ff;
   logic [alt_pkg::CHAR_W-1:0] last_ff;

   // counters
   logic [alt_pkg::LINE_NUM_W-1:0] line_ff;
   logic [ADDR_BITS-1:0]           addr_ff;

   // emission state
   logic [alt_pkg::LINE_NUM_W-1:0] emit_line_ff;
   logic [ADDR_BITS-1:0]           emit_addr_ff;
   logic [alt_pkg::KIND_W-1:0]     kind_ff;
   logic [IDX_W-1:0]               idx_ff;
   logic [alt_pkg::CHAR_W-1:0]     rd_char_ff;
   logic [alt_pkg::PART_W-1:0]     part_ff;
   logic                           fin_ff;

   logic [alt_pkg::CHAR_W-1:0]     wr_char;
   logic                           store_en;
   logic                           room;
   logic [IDX_W-1:0]               wr_idx;
   logic [alt_pkg::KIND_W-1:0]     kind_in;
   logic [alt_pkg::LINE_NUM_W-1:0] line_inc;
   logic [LEN_W-1:0]               idx_next_len;
   logic                           fin_in;
   logic [alt_pkg::PART_W-1:0]     part_in;
   logic [ADDR_BITS+15:0]          addr_wide;

   // store source select
   always_comb begin
      case (cmd.store_sel)
         alt_pkg::STORE_INPUT: wr_char = req_tdata;
         alt_pkg::STORE_SLASH: wr_char = alt_pkg::CH_SLASH;
         alt_pkg::STORE_HELD:  wr_char = char_ff;
         default:              wr_char = req_tdata;
      endcase
   end

   assign store_en = (cmd.store_sel != alt_pkg::STORE_NONE);
   assign room     = (len_ff < LEN_W'(LINE_MAX));
   assign wr_idx   = len_ff[IDX_W-1:0];

   // classification of the buffered line
   always_comb begin
      if (first_ff == alt_pkg::CH_AT) begin
         kind_in = alt_pkg::KIND_ADDRESS;
      end else if (first_ff == alt_pkg::CH_LPAREN && last_ff == alt_pkg::CH_RPAREN) begin
         kind_in = alt_pkg::KIND_LABEL;
      end else begin
         kind_in = alt_pkg::KIND_COMPUTE;
      end
   end

   assign line_inc = (line_ff != alt_pkg::LINE_SAT) ? line_ff + 1'b1 : line_ff;

   // tag of the character being read
   assign idx_next_len = LEN_W'(idx_ff) + 1'b1;
   assign fin_in       = (idx_next_len == len_ff);

   always_comb begin
      case (kind_ff)
         alt_pkg::KIND_ADDRESS: begin
            part_in = (idx_ff == '0) ? alt_pkg::PART_DELIM : alt_pkg::PART_SYMBOL;
         end
         alt_pkg::KIND_LABEL: begin
            part_in = (idx_ff == '0 || fin_in) ? alt_pkg::PART_DELIM : alt_pkg::PART_SYMBOL;
         end
         default: begin
            if ((eq_seen_ff && idx_ff == eq_pos_ff) || (sc_seen_ff && idx_ff == sc_pos_ff)) begin
               part_in = alt_pkg::PART_DELIM;
            end else if (eq_seen_ff && idx_ff < eq_pos_ff) begin
               part_in = alt_pkg::PART_DEST;
            end else if (sc_seen_ff && idx_ff > sc_pos_ff) begin
               part_in = alt_pkg::PART_JUMP;
            end else begin
               part_in = alt_pkg::PART_COMP;
            end
         end
      endcase
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= req_tdata;
         end_ff  <= req_tuser[0];
      end
   end

   // line buffer write
   always_ff @(posedge clock) begin
      if (store_en && room) begin
         mem[wr_idx] <= wr_char;
      end
   end

   // buffer read with result tag
   always_ff @(posedge clock) begin
      if (cmd.read_char) begin
         rd_char_ff <= mem[idx_ff];
         part_ff    <= part_in;
         fin_ff     <= fin_in;
      end
   end

   // first and last kept characters
   always_ff @(posedge clock) begin
      if (store_en && room) begin
         last_ff <= wr_char;
         if (len_ff == '0) begin
            first_ff <= wr_char;
         end
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         slash_ff   <= 1'b0;
         comment_ff <= 1'b0;
         eq_seen_ff <= 1'b0;
         sc_seen_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         if (store_en) begin
            if (room) begin
               len_ff <= len_ff + 1'b1;
               if (wr_char == alt_pkg::CH_EQUALS && !eq_seen_ff) begin
                  eq_seen_ff <= 1'b1;
               end
               if (wr_char == alt_pkg::CH_SEMICOLON && !sc_seen_ff) begin
                  sc_seen_ff <= 1'b1;
               end
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.set_slash) begin
            slash_ff <= 1'b1;
         end
         if (cmd.clr_slash) begin
            slash_ff <= 1'b0;
         end
         if (cmd.set_comment) begin
            comment_ff <= 1'b1;
         end
         if (cmd.clear_line) begin
            len_ff     <= '0;
            slash_ff   <= 1'b0;
            comment_ff <= 1'b0;
            eq_seen_ff <= 1'b0;
            sc_seen_ff <= 1'b0;
            ovf_ff     <= 1'b0;
         end
      end
   end

   // delimiter positions
   always_ff @(posedge clock) begin
      if (store_en && room) begin
         if (wr_char == alt_pkg::CH_EQUALS && !eq_seen_ff) begin
            eq_pos_ff <= wr_idx;
         end
         if (wr_char == alt_pkg::CH_SEMICOLON && !sc_seen_ff) begin
            sc_pos_ff <= wr_idx;
         end
      end
   end

   // line and address counters
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         addr_ff <= '1;
      end else if (cmd.classify) begin
         if (end_ff) begin
            line_ff <= '0;
            addr_ff <= '1;
         end else begin
            line_ff <= line_inc;
            if (len_ff != '0 && kind_in != alt_pkg::KIND_LABEL) begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
      end
   end

   // emission snapshot and read pointer
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         emit_line_ff <= line_inc;
         emit_addr_ff <= addr_ff + 1'b1;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.classify) begin
         idx_ff <= '0;
      end else if (cmd.next_char) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // status to the controller
   always_comb begin
      status.in_comment    = comment_ff;
      status.slash_pending = slash_ff;
      status.is_end        = req_tuser[0];
      status.is_newline    = (req_tdata == alt_pkg::CH_NEWLINE);
      status.is_slash      = (req_tdata == alt_pkg::CH_SLASH);
      status.is_blank      = (req_tdata == alt_pkg::CH_SPACE) || (req_tdata == alt_pkg::CH_TAB);
      status.line_empty    = (len_ff == '0);
      status.emit_final    = fin_ff;
   end

   // result packing
   assign addr_wide = {16'b0, emit_addr_ff};
   assign rsp_tdata = {4'b0, addr_wide[alt_pkg::OUT_ADDR_W-1:0], emit_line_ff, rd_char_ff};
   assign rsp_tuser = {ovf_ff, kind_ff, part_ff};
   assign rsp_tlast = fin_ff;

   // checks
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_MAX))
      else $error("line length beyond buffer");

   a_read_in_line : assert property (@(posedge clock) disable iff (reset)
      cmd.read_char |-> (LEN_W'(idx_ff) < len_ff))
      else $error("read past kept characters");

   a_eq_in_line : assert property (@(posedge clock) disable iff (reset)
      eq_seen_ff |-> (LEN_W'(eq_pos_ff) < len_ff))
      else $error("equals position outside line");

endmodule

`default_nettype wire

### sv/alt_ctrl.sv
// ----------------------------------------------------------------------------
// alt_ctrl
// Controller of the tokenizer: takes bytes, sequences the extra store of a
// held character after a lone slash, classifies a finished line and steps through its emission.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire alt_pkg::status_type  status,
   output alt_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_STORE2   = 3'd1;
   localparam logic [2:0] S_CLASSIFY = 3'd2;
   localparam logic [2:0] S_READ     = 3'd3;
   localparam logic [2:0] S_SHOW     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SHOW);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.is_end || status.is_newline) begin
                  // pending slash is kept before the line closes
                  if (status.slash_pending && (status.is_end || !status.in_comment)) begin
                     cmd.store_sel = alt_pkg::STORE_SLASH;
                     cmd.clr_slash = 1'b1;
                  end
                  state_in = S_CLASSIFY;
               end else if (status.in_comment) begin
                  cmd.store_sel = alt_pkg::STORE_NONE;
               end else if (status.slash_pending) begin
                  cmd.clr_slash = 1'b1;
                  if (status.is_slash) begin
                     cmd.set_comment = 1'b1;
                  end else begin
                     cmd.store_sel = alt_pkg::STORE_SLASH;
                     if (!status.is_blank) begin
                        state_in = S_STORE2;
                     end
                  end
               end else if (status.is_slash) begin
                  cmd.set_slash = 1'b1;
               end else if (!status.is_blank) begin
                  cmd.store_sel = alt_pkg::STORE_INPUT;
               end
            end
         end
         S_STORE2: begin
            cmd.store_sel = alt_pkg::STORE_HELD;
            state_in      = S_IDLE;
         end
         S_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (status.line_empty) begin
               cmd.clear_line = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read_char = 1'b1;
            state_in      = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_tready) begin
               if (status.emit_final) begin
                  cmd.clear_line = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.next_char = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_one_side : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides open together");

   a_end_classify : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid && (status.is_end || status.is_newline))
         |=> (state_ff == S_CLASSIFY))
      else $error("line end not followed by classify");

   a_read_show : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_SHOW))
      else $error("buffer read not followed by result");

   a_store2_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE2) |=> (state_ff == S_IDLE))
      else $error("held character store did not return to idle");

endmodule

`default_nettype wire

### sv/assembly_line_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_line_tokenizer
// Splits assembly source into tagged characters of commands, one line at a
// time, with line number and instruction address on every result.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one source byte per transfer; req_tuser marks end of input,
//   which flushes the pending line and restarts the line and address counts.
//   rsp_* gives one transfer per kept character of a non-empty line, with
//   rsp_tlast on the final character of the command.
// Flow:
//   an ordinary byte is taken straight from idle; a kept byte right after a lone
//   slash also goes through an extra store state, as both characters go through
//   the single buffer write port. A newline or end of input is accepted, then the
//   line is classified, then each kept character goes through a buffer read, then
//   the result register. Input is not taken while a line is being emitted.
// Reset:
//   clears the line length, the line flags and the counters; the first address or compute
//   command gets address 0. No clearing pass of the line buffer is needed.
// Stall:
//   a stalled result holds in place until rsp_tready is seen high.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_line_tokenizer #(
   parameter int LINE_MAX  = alt_pkg::LINE_MAX_DEFAULT,
   parameter int ADDR_BITS = alt_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_code[7:0]
   input  wire logic [0:0]  req_tuser,   // end_of_input[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // out_char[7:0], line_number[27:8],
                                         // instr_address[43:28], zero[47:44]
   output logic [5:0]       rsp_tuser,   // part[2:0], command_type[4:3], truncated[5]
   output logic             rsp_tlast
);

   alt_pkg::cmd_type    cmd;
   alt_pkg::status_type status;

   alt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   alt_dpath #(
      .LINE_MAX  (LINE_MAX),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire
